@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define KCG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kcg assertion failed");

// Clocked assertion that also holds during reset.
`define KCG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kcg assertion failed");

`endif

@@ src/kcg_pkg.sv @@
`default_nettype none
package kcg_pkg;

  // Field widths
  localparam int TIME_W      = 16;
  localparam int FRAC_W      = 17;
  localparam int QUO_W       = 16;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 6;
  localparam int KEY_W       = 64;
  localparam int KEY_REGS    = 4;
  localparam int KEY_IDX_W   = 2;
  localparam int KEY_COUNT_W = 3;
  localparam int PROD_W      = CHAN_W + FRAC_W;

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  // Register map, 64-bit registers at 8-byte spacing
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_0     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_3     = 3'd4;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 3'd4;
  localparam logic [KEY_W-1:0] KEY_RESET [KEY_REGS] = '{
    64'd11038905470790,
    64'd4611796660237407844,
    64'd9223394460865571528,
    64'd13835124200388851812
  };

  // Stage 1: segment found
  typedef struct packed {
    logic                 valid;
    logic [TIME_W-1:0]    day_time;
    logic [KEY_IDX_W-1:0] idx;
    logic [KEY_IDX_W-1:0] nxt;
    logic                 wrap;
  } seg_t;

  // Divider stages: len and rem carried with the partial quotient
  typedef struct packed {
    logic                 valid;
    logic [KEY_IDX_W-1:0] idx;
    logic [KEY_IDX_W-1:0] nxt;
    logic                 full;
    logic                 zero;
    logic [FRAC_W-1:0]    len;
    logic [FRAC_W-1:0]    rem;
    logic [QUO_W-1:0]     quo;
  } div_t;

  // Blend products
  typedef struct packed {
    logic                               valid;
    logic [KEY_IDX_W-1:0]               idx;
    logic [FRAC_W-1:0]                  frac;
    logic [NUM_CHAN-1:0][PROD_W-1:0]    prod_a;
    logic [NUM_CHAN-1:0][PROD_W-1:0]    prod_b;
  } mul_t;

  function automatic logic [TIME_W-1:0] key_time(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: TIME_W];
  endfunction

  // Channel 0..5: top r,g,b then bottom r,g,b
  function automatic logic [CHAN_W-1:0] key_chan(input logic [KEY_W-1:0] k,
                                                 input logic [2:0] ch);
    logic [5:0] sh;
    sh = 6'd40 - {ch, 3'b000};
    return CHAN_W'(k >> sh);
  endfunction

endpackage
`default_nettype wire

@@ src/kcg_in_if.sv @@
`default_nettype none
interface kcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [kcg_pkg::TIME_W-1:0]  day_time;

  modport source (output valid, output day_time, input ready);
  modport sink   (input valid, input day_time, output ready);
endinterface
`default_nettype wire

@@ src/kcg_out_if.sv @@
`default_nettype none
interface kcg_out_if;
  logic                          valid;
  logic                          ready;
  logic [kcg_pkg::CHAN_W-1:0]    top_red;
  logic [kcg_pkg::CHAN_W-1:0]    top_green;
  logic [kcg_pkg::CHAN_W-1:0]    top_blue;
  logic [kcg_pkg::CHAN_W-1:0]    bottom_red;
  logic [kcg_pkg::CHAN_W-1:0]    bottom_green;
  logic [kcg_pkg::CHAN_W-1:0]    bottom_blue;
  logic [kcg_pkg::KEY_IDX_W-1:0] segment_index;
  logic [kcg_pkg::FRAC_W-1:0]    local_fraction;

  modport source (output valid, output top_red, output top_green, output top_blue,
                  output bottom_red, output bottom_green, output bottom_blue,
                  output segment_index, output local_fraction, input ready);
  modport sink   (input valid, input top_red, input top_green, input top_blue,
                  input bottom_red, input bottom_green, input bottom_blue,
                  input segment_index, input local_fraction, output ready);
endinterface
`default_nettype wire

@@ src/keyframe_color_gradient.sv @@
`default_nettype none
// Keyframe sky gradient: each day_time beat picks the active keyframe segment
// (the last key wraps to key 0 at the end of the day), computes the local
// fraction floor((t - t_i) * 65536 / length) clamped to 0..65536, and blends
// the top and bottom colors of the two keys. A new beat is taken every clock
// while the pipeline is not held; a beat passes 12 register stages (segment
// search, length/offset, eight divider stages resolving two quotient bits
// each, blend multiply and blend sum) before it reaches the output. The whole
// pipeline holds when the result beat is not taken, so sample.ready follows
// gradient.ready. Keys are to be written over the APB port only while the
// block is idle; the block itself does not enforce this.
module keyframe_color_gradient #(
  parameter int MAX_KEYS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcg_pkg::ADDR_W-1:0]  paddr,
  input  logic [kcg_pkg::KEY_W-1:0]   pwdata,
  output logic [kcg_pkg::KEY_W-1:0]   prdata,
  output logic                        pready,
  kcg_in_if.sink                      sample,
  kcg_out_if.source                   gradient
);

  // Configuration registers
  logic [kcg_pkg::KEY_COUNT_W-1:0] key_count;
  logic [kcg_pkg::KEY_W-1:0]       keys [kcg_pkg::KEY_REGS];
  logic [kcg_pkg::REG_IDX_W-1:0]   reg_sel;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[kcg_pkg::ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kcg_pkg::KEY_COUNT_RESET;
      for (int k = 0; k < kcg_pkg::KEY_REGS; k++) begin
        keys[k] <= kcg_pkg::KEY_RESET[k];
      end
    end else if (cfg_wr) begin
      if (reg_sel == kcg_pkg::REG_KEY_COUNT) begin
        key_count <= pwdata[kcg_pkg::KEY_COUNT_W-1:0];
      end else if (reg_sel inside {[kcg_pkg::REG_KEY_0:kcg_pkg::REG_KEY_3]}) begin
        keys[kcg_pkg::KEY_IDX_W'(reg_sel - kcg_pkg::REG_KEY_0)] <= pwdata;
      end
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (reg_sel == kcg_pkg::REG_KEY_COUNT) begin
      prdata = kcg_pkg::KEY_W'(key_count);
    end else if (reg_sel inside {[kcg_pkg::REG_KEY_0:kcg_pkg::REG_KEY_3]}) begin
      prdata = keys[kcg_pkg::KEY_IDX_W'(reg_sel - kcg_pkg::REG_KEY_0)];
    end
  end

  // Pipeline advance: moves whenever the output slot is free or drains
  logic adv;
  logic out_valid;

  assign adv          = !out_valid || gradient.ready;
  assign sample.ready = adv;

  // Stage 1: segment search
  kcg_pkg::seg_t                  seg;
  logic [kcg_pkg::KEY_COUNT_W-1:0] n_use;
  logic [kcg_pkg::KEY_COUNT_W-1:0] nxt3;
  logic [kcg_pkg::KEY_IDX_W-1:0]   idx_c;
  logic [kcg_pkg::KEY_IDX_W-1:0]   nxt_c;
  logic                            wrap_c;

  always_comb begin
    n_use = key_count;
    if (key_count == '0) begin
      n_use = kcg_pkg::KEY_COUNT_W'(1);
    end else if (key_count > kcg_pkg::KEY_COUNT_W'(MAX_KEYS)) begin
      n_use = kcg_pkg::KEY_COUNT_W'(MAX_KEYS);
    end
    // default: last key in use, wrapping segment
    idx_c  = kcg_pkg::KEY_IDX_W'(n_use - kcg_pkg::KEY_COUNT_W'(1));
    wrap_c = 1'b1;
    // downward scan so the lowest matching key wins
    for (int i = MAX_KEYS - 2; i >= 0; i--) begin
      if (kcg_pkg::KEY_COUNT_W'(i + 1) < n_use &&
          sample.day_time < kcg_pkg::key_time(keys[i + 1])) begin
        idx_c  = kcg_pkg::KEY_IDX_W'(i);
        wrap_c = 1'b0;
      end
    end
    nxt3  = {1'b0, idx_c} + kcg_pkg::KEY_COUNT_W'(1);
    nxt_c = (nxt3 == n_use) ? '0 : nxt3[kcg_pkg::KEY_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (adv) begin
      seg.valid    <= sample.valid;
      seg.day_time <= sample.day_time;
      seg.idx      <= idx_c;
      seg.nxt      <= nxt_c;
      seg.wrap     <= wrap_c;
    end
  end

  // Stage 2: segment length, offset, and the out-of-range cases
  kcg_pkg::div_t                 div [0:kcg_pkg::DIV_STAGES];
  logic [kcg_pkg::TIME_W-1:0]    t_start;
  logic [kcg_pkg::TIME_W-1:0]    t_next;
  logic signed [kcg_pkg::FRAC_W:0] len_s;
  logic signed [kcg_pkg::FRAC_W:0] num_s;
  logic                          len_pos;
  logic                          num_neg;

  always_comb begin
    t_start = kcg_pkg::key_time(keys[seg.idx]);
    t_next  = kcg_pkg::key_time(keys[seg.nxt]);
    if (seg.wrap) begin
      len_s = $signed({1'b0, kcg_pkg::FRAC_ONE}) - $signed({2'b00, t_start});
    end else begin
      len_s = $signed({2'b00, t_next}) - $signed({2'b00, t_start});
    end
    num_s   = $signed({2'b00, seg.day_time}) - $signed({2'b00, t_start});
    len_pos = len_s > 0;
    num_neg = num_s < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div[0].valid <= 1'b0;
    end else if (adv) begin
      div[0].valid <= seg.valid;
      div[0].idx   <= seg.idx;
      div[0].nxt   <= seg.nxt;
      // quotient would reach 65536 or length is not positive
      div[0].full  <= !len_pos || (!num_neg && num_s >= len_s);
      div[0].zero  <= len_pos && num_neg;
      div[0].len   <= len_s[kcg_pkg::FRAC_W-1:0];
      div[0].rem   <= num_s[kcg_pkg::FRAC_W-1:0];
      div[0].quo   <= '0;
    end
  end

  // Divider stages: restoring division, rem < len throughout for in-range beats
  for (genvar g = 0; g < kcg_pkg::DIV_STAGES; g++) begin : g_div
    kcg_pkg::div_t              step;
    logic [kcg_pkg::FRAC_W:0]   rem2;

    always_comb begin
      step = div[g];
      rem2 = '0;
      for (int k = 0; k < kcg_pkg::DIV_STEPS; k++) begin
        rem2 = {step.rem, 1'b0};
        if (rem2 >= {1'b0, step.len}) begin
          step.rem = kcg_pkg::FRAC_W'(rem2 - {1'b0, step.len});
          step.quo = {step.quo[kcg_pkg::QUO_W-2:0], 1'b1};
        end else begin
          step.rem = rem2[kcg_pkg::FRAC_W-1:0];
          step.quo = {step.quo[kcg_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div[g+1].valid <= 1'b0;
      end else if (adv) begin
        div[g+1] <= step;
      end
    end
  end

  // Blend multiply: a*(1-f) and b*f per channel
  kcg_pkg::mul_t               mul;
  kcg_pkg::div_t               dl;
  logic [kcg_pkg::FRAC_W-1:0]  frac_c;
  logic [kcg_pkg::FRAC_W-1:0]  w_a;
  logic [kcg_pkg::NUM_CHAN-1:0][kcg_pkg::PROD_W-1:0] pa_c;
  logic [kcg_pkg::NUM_CHAN-1:0][kcg_pkg::PROD_W-1:0] pb_c;

  always_comb begin
    dl = div[kcg_pkg::DIV_STAGES];
    if (dl.full) begin
      frac_c = kcg_pkg::FRAC_ONE;
    end else if (dl.zero) begin
      frac_c = '0;
    end else begin
      frac_c = {1'b0, dl.quo};
    end
    w_a = kcg_pkg::FRAC_ONE - frac_c;
    for (int ch = 0; ch < kcg_pkg::NUM_CHAN; ch++) begin
      pa_c[ch] = kcg_pkg::PROD_W'(kcg_pkg::key_chan(keys[dl.idx], 3'(ch))) *
                 kcg_pkg::PROD_W'(w_a);
      pb_c[ch] = kcg_pkg::PROD_W'(kcg_pkg::key_chan(keys[dl.nxt], 3'(ch))) *
                 kcg_pkg::PROD_W'(frac_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul.valid <= 1'b0;
    end else if (adv) begin
      mul.valid  <= dl.valid;
      mul.idx    <= dl.idx;
      mul.frac   <= frac_c;
      mul.prod_a <= pa_c;
      mul.prod_b <= pb_c;
    end
  end

  // Blend sum and output register; floor is the drop of the low 16 bits
  logic [kcg_pkg::NUM_CHAN-1:0][kcg_pkg::CHAN_W-1:0] chan_c;
  logic [kcg_pkg::NUM_CHAN-1:0][kcg_pkg::CHAN_W-1:0] out_chan;
  logic [kcg_pkg::KEY_IDX_W-1:0]                     out_idx;
  logic [kcg_pkg::FRAC_W-1:0]                        out_frac;
  logic [kcg_pkg::PROD_W-1:0]                        sum;

  always_comb begin
    sum = '0;
    for (int ch = 0; ch < kcg_pkg::NUM_CHAN; ch++) begin
      sum        = mul.prod_a[ch] + mul.prod_b[ch];
      chan_c[ch] = sum[kcg_pkg::QUO_W +: kcg_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mul.valid;
      out_chan  <= chan_c;
      out_idx   <= mul.idx;
      out_frac  <= mul.frac;
    end
  end

  assign gradient.valid          = out_valid;
  assign gradient.top_red        = out_chan[0];
  assign gradient.top_green      = out_chan[1];
  assign gradient.top_blue       = out_chan[2];
  assign gradient.bottom_red     = out_chan[3];
  assign gradient.bottom_green   = out_chan[4];
  assign gradient.bottom_blue    = out_chan[5];
  assign gradient.segment_index  = out_idx;
  assign gradient.local_fraction = out_frac;

endmodule
`default_nettype wire

@@ src/kcg_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the gradient block
module kcg_checker (
  input logic        clk,
  input logic        rst,
  kcg_in_if.sink     sample,
  kcg_out_if.source  gradient
);

  // nothing leaves the pipeline right after reset
  `KCG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !gradient.valid)

  // input stalls only behind a held result beat
  `KCG_ASSERT(a_stall_cause, clk, rst, !sample.ready |-> gradient.valid && !gradient.ready)

  // fraction never passes the segment end
  `KCG_ASSERT(a_frac_range, clk, rst, gradient.valid |-> gradient.local_fraction <= 17'd65536)

  // a held result beat keeps its payload
  `KCG_ASSERT(a_out_hold, clk, rst, gradient.valid && !gradient.ready |=> gradient.valid && $stable(gradient.local_fraction) && $stable(gradient.top_red) && $stable(gradient.bottom_blue) && $stable(gradient.segment_index))

endmodule

bind keyframe_color_gradient kcg_checker u_kcg_checker (
  .clk      (clk),
  .rst      (rst),
  .sample   (sample),
  .gradient (gradient)
);
`default_nettype wire
